/* src/aez_pkg.sv */
// Shared constants, arctangent table and types for the az/el to X/Y mount converter.
// No dependencies; used by every module of the block.
`default_nettype none
package aez_pkg;
    localparam int ANGLE_FRAC_BITS_DEF = 10;
    localparam int QDEG                = 22;
    localparam int CORDIC_STEPS        = 26;
    localparam int SQRT_STEPS          = 32;
    localparam int ANG_W               = 34;
    localparam int PROD_W              = 64;
    localparam int AZ_W                = 19;
    localparam int EL_W                = 17;
    localparam int AXIS_W              = 18;
    localparam int MARGIN_W            = 11;
    localparam int IN_TDATA_W          = 40;
    localparam int OUT_TDATA_W         = 40;
    localparam int PADDR_W             = 3;
    localparam int PDATA_W             = 32;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 11'd10;
    localparam logic [0:0] REG_MARGIN = 1'b0;

    localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] DEG90_Q  = 34'sd377487360;
    localparam logic signed [ANG_W-1:0] DEG180_Q = 34'sd754974720;
    localparam logic signed [ANG_W-1:0] DEG360_Q = 34'sd1509949440;
    localparam logic signed [ANG_W-1:0] ONE_Q30  = 34'sd1073741824;

    typedef logic signed [ANG_W-1:0] t_ang;

    typedef struct packed {
        logic force_90;
        logic force_0;
    } t_xclamp;

    function automatic t_ang atan_q(input int idx);
        t_ang v;
        case (idx)
            0:  v = 34'sd188743680;
            1:  v = 34'sd111421900;
            2:  v = 34'sd58872272;
            3:  v = 34'sd29884485;
            4:  v = 34'sd15000234;
            5:  v = 34'sd7507429;
            6:  v = 34'sd3754631;
            7:  v = 34'sd1877430;
            8:  v = 34'sd938729;
            9:  v = 34'sd469366;
            10: v = 34'sd234683;
            11: v = 34'sd117342;
            12: v = 34'sd58671;
            13: v = 34'sd29335;
            14: v = 34'sd14668;
            15: v = 34'sd7334;
            16: v = 34'sd3667;
            17: v = 34'sd1833;
            18: v = 34'sd917;
            19: v = 34'sd458;
            20: v = 34'sd229;
            21: v = 34'sd115;
            22: v = 34'sd57;
            23: v = 34'sd29;
            24: v = 34'sd14;
            25: v = 34'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

/* src/aez_cordic_rot.sv */
// Pipelined rotation CORDIC, one micro-rotation per stage: angle in, cos and sin in Q30 out.
// Depends on aez_pkg.
`default_nettype none
module aez_cordic_rot #(
    parameter int SIDE_W = 1
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  wire  aez_pkg::t_ang      i_ang,
    input  wire  [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output aez_pkg::t_ang            o_cos,
    output aez_pkg::t_ang            o_sin,
    output logic [SIDE_W-1:0]        o_side
);
    localparam int N = aez_pkg::CORDIC_STEPS;

    aez_pkg::t_ang     r_x [N];
    aez_pkg::t_ang     r_y [N];
    aez_pkg::t_ang     r_z [N];
    logic [SIDE_W-1:0] r_side [N];
    logic              r_vld [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        aez_pkg::t_ang     px, py, pz;
        logic [SIDE_W-1:0] ps;
        logic              pv;
        if (i == 0) begin : g_first
            assign px = aez_pkg::CORDIC_GAIN_Q30;
            assign py = '0;
            assign pz = i_ang;
            assign ps = i_side;
            assign pv = i_valid;
        end else begin : g_next
            assign px = r_x[i-1];
            assign py = r_y[i-1];
            assign pz = r_z[i-1];
            assign ps = r_side[i-1];
            assign pv = r_vld[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (pz >= 0) begin
                    r_x[i] <= px - (py >>> i);
                    r_y[i] <= py + (px >>> i);
                    r_z[i] <= pz - aez_pkg::atan_q(i);
                end else begin
                    r_x[i] <= px + (py >>> i);
                    r_y[i] <= py - (px >>> i);
                    r_z[i] <= pz + aez_pkg::atan_q(i);
                end
                r_side[i] <= ps;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_cos   = r_x[N-1];
    assign o_sin   = r_y[N-1];
    assign o_side  = r_side[N-1];
endmodule
`default_nettype wire

/* src/aez_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with a sideband carried alongside.
// Depends on aez_pkg.
`default_nettype none
module aez_isqrt #(
    parameter int SIDE_W = 1
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  wire  [63:0]              i_n,
    input  wire  [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic [31:0]              o_root,
    output logic [SIDE_W-1:0]        o_side
);
    localparam int N = aez_pkg::SQRT_STEPS;

    logic [63:0]       r_n [N];
    logic [63:0]       r_res [N];
    logic [SIDE_W-1:0] r_side [N];
    logic              r_vld [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
        logic [63:0]       pn, pres, trial;
        logic [SIDE_W-1:0] ps;
        logic              pv;
        if (k == 0) begin : g_first
            assign pn   = i_n;
            assign pres = '0;
            assign ps   = i_side;
            assign pv   = i_valid;
        end else begin : g_next
            assign pn   = r_n[k-1];
            assign pres = r_res[k-1];
            assign ps   = r_side[k-1];
            assign pv   = r_vld[k-1];
        end
        assign trial = pres + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (pn >= trial) begin
                    r_n[k]   <= pn - trial;
                    r_res[k] <= (pres >> 1) + BIT;
                end else begin
                    r_n[k]   <= pn;
                    r_res[k] <= pres >> 1;
                end
                r_side[k] <= ps;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_res[N-1][31:0];
    assign o_side  = r_side[N-1];
endmodule
`default_nettype wire

/* src/aez_cordic_vec.sv */
// Pipelined vectoring CORDIC: angle of (x, y) in Q22 degrees, with half-plane pre-rotation.
// Depends on aez_pkg.
`default_nettype none
module aez_cordic_vec #(
    parameter int SIDE_W = 1
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  wire  aez_pkg::t_ang      i_x,
    input  wire  aez_pkg::t_ang      i_y,
    input  wire  [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output aez_pkg::t_ang            o_ang,
    output logic [SIDE_W-1:0]        o_side
);
    localparam int N = aez_pkg::CORDIC_STEPS;

    aez_pkg::t_ang     r_x [N+1];
    aez_pkg::t_ang     r_y [N+1];
    aez_pkg::t_ang     r_z [N+1];
    logic [SIDE_W-1:0] r_side [N+1];
    logic              r_vld [N+1];

    // half-plane fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? aez_pkg::DEG180_Q : -aez_pkg::DEG180_Q;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
            r_side[0] <= i_side;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + aez_pkg::atan_q(i);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - aez_pkg::atan_q(i);
                end
                r_side[i+1] <= r_side[i];
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_ang   = r_z[N];
    assign o_side  = r_side[N];
endmodule
`default_nettype wire

/* src/az_el_to_xy_mount_angles_unit.sv */
// Az/el to X/Y mount angle converter: top level with front end, products, output stage.
// Depends on aez_pkg, aez_cordic_rot, aez_isqrt, aez_cordic_vec.
//
// Usage:
//   Input stream (i_s_*): one pointing word per handshake, azimuth and elevation in
//   2^-ANGLE_FRAC_BITS degree. Output stream (o_m_*): one X/Y axis word per input word,
//   in input order. APB port: register 0 at address 0 holds the horizon/zenith margin
//   (reset 10); write it only while the pipeline is empty.
//   Throughput: one word per cycle while the receiver does not stall. Pipeline from input
//   handshake to o_m_tvalid: 1 front-end stage, 26 sin/cos CORDIC stages, 4 product/square
//   stages, 32 square-root stages, 27 atan2 CORDIC stages and the output register. The
//   square-root and the two CORDIC chains make up most of that depth.
//   Reset (synchronous, active low) empties the pipeline and restores the margin.
//   When the receiver stalls, the whole pipeline holds in place and o_s_tready drops; no
//   word is lost or repeated.
`default_nettype none
module az_el_to_xy_mount_angles_unit #(
    parameter int ANGLE_FRAC_BITS = aez_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [aez_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // azimuth[18:0], elevation[35:19]
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [aez_pkg::OUT_TDATA_W-1:0]    o_m_tdata,  // axis_x[17:0], axis_y[35:18]
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [aez_pkg::PADDR_W-1:0]        paddr,
    input  wire  [aez_pkg::PDATA_W-1:0]        pwdata,
    output logic [aez_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    localparam int SH = aez_pkg::QDEG - ANGLE_FRAC_BITS;
    localparam logic [63:0] AZ_MAX = 64'(360) << ANGLE_FRAC_BITS;
    localparam logic [63:0] EL_MAX = 64'(90) << ANGLE_FRAC_BITS;
    localparam logic [63:0] X90    = 64'(90) << ANGLE_FRAC_BITS;
    localparam logic signed [35:0] HALF = 36'(64'(1) << (SH - 1));
    localparam int AW = aez_pkg::ANG_W;
    localparam int ISIDE_W = 3 * AW + 2;

    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // configuration
    logic [aez_pkg::MARGIN_W-1:0] r_margin;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= aez_pkg::MARGIN_RESET;
        end else if (psel && penable && pwrite && paddr[2] == aez_pkg::REG_MARGIN) begin
            r_margin <= pwdata[aez_pkg::MARGIN_W-1:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr[2] == aez_pkg::REG_MARGIN) ?
                    aez_pkg::PDATA_W'(r_margin) : '0;

    // front end: saturate, reduce azimuth, clamp flags
    logic [63:0] az_s, el_s;
    logic signed [35:0] a0, a1, a2;
    logic signed [63:0] el_sg, m_sg;
    logic neg;
    aez_pkg::t_xclamp fclamp;

    always_comb begin
        az_s = (64'(i_s_tdata[18:0]) > AZ_MAX) ? AZ_MAX : 64'(i_s_tdata[18:0]);
        el_s = (64'(i_s_tdata[35:19]) > EL_MAX) ? EL_MAX : 64'(i_s_tdata[35:19]);
        a0 = 36'(az_s << SH);
        a1 = (a0 > 36'(aez_pkg::DEG180_Q)) ? a0 - 36'(aez_pkg::DEG360_Q) : a0;
        neg = 1'b0;
        a2 = a1;
        if (a1 > 36'(aez_pkg::DEG90_Q)) begin
            a2  = a1 - 36'(aez_pkg::DEG180_Q);
            neg = 1'b1;
        end else if (a1 < -36'(aez_pkg::DEG90_Q)) begin
            a2  = a1 + 36'(aez_pkg::DEG180_Q);
            neg = 1'b1;
        end
        el_sg = $signed(el_s);
        m_sg  = $signed(64'(r_margin));
        fclamp.force_90 = (el_sg <= m_sg);
        fclamp.force_0  = !fclamp.force_90 && (el_sg >= $signed(EL_MAX) - m_sg);
    end

    logic             r_f_vld, r_f_neg;
    aez_pkg::t_ang    r_f_a, r_f_e;
    aez_pkg::t_xclamp r_f_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_a     <= a2[AW-1:0];
            r_f_e     <= AW'(el_s << SH);
            r_f_neg   <= neg;
            r_f_clamp <= fclamp;
        end
    end

    // sin/cos
    logic             az_vld, el_vld_unused, az_neg;
    aez_pkg::t_ang    ca, sa, ce, se;
    aez_pkg::t_xclamp el_clamp;

    aez_cordic_rot #(.SIDE_W(1)) u_rot_az (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_f_vld), .i_ang(r_f_a), .i_side(r_f_neg),
        .o_valid(az_vld), .o_cos(ca), .o_sin(sa), .o_side(az_neg)
    );

    aez_cordic_rot #(.SIDE_W(2)) u_rot_el (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_f_vld), .i_ang(r_f_e), .i_side(r_f_clamp),
        .o_valid(el_vld_unused), .o_cos(ce), .o_sin(se), .o_side(el_clamp)
    );

    // M1: raw products
    logic                       r_m1_vld, r_m1_neg;
    logic signed [63:0]         r_m1_ps, r_m1_pc;
    aez_pkg::t_ang              r_m1_se;
    aez_pkg::t_xclamp           r_m1_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (en) begin
            r_m1_vld <= az_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_ps    <= $signed(sa[31:0]) * $signed(ce[31:0]);
            r_m1_pc    <= $signed(ca[31:0]) * $signed(ce[31:0]);
            r_m1_se    <= se;
            r_m1_neg   <= az_neg;
            r_m1_clamp <= el_clamp;
        end
    end

    // M2: sign fix, scale, clamp
    logic signed [63:0] ps_n, pc_n, s_full, xc_full;
    logic signed [63:0] s_cl;
    always_comb begin
        ps_n    = r_m1_neg ? -r_m1_ps : r_m1_ps;
        pc_n    = r_m1_neg ? -r_m1_pc : r_m1_pc;
        s_full  = ps_n >>> 30;
        xc_full = -(pc_n >>> 30);
        if (s_full > 64'(aez_pkg::ONE_Q30)) begin
            s_cl = 64'(aez_pkg::ONE_Q30);
        end else if (s_full < -64'(aez_pkg::ONE_Q30)) begin
            s_cl = -64'(aez_pkg::ONE_Q30);
        end else begin
            s_cl = s_full;
        end
    end

    logic             r_m2_vld;
    aez_pkg::t_ang    r_m2_s, r_m2_xc, r_m2_se;
    aez_pkg::t_xclamp r_m2_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (en) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_s     <= s_cl[AW-1:0];
            r_m2_xc    <= xc_full[AW-1:0];
            r_m2_se    <= r_m1_se;
            r_m2_clamp <= r_m1_clamp;
        end
    end

    // M3: square
    logic               r_m3_vld;
    logic signed [63:0] r_m3_sq;
    aez_pkg::t_ang      r_m3_s, r_m3_xc, r_m3_se;
    aez_pkg::t_xclamp   r_m3_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else if (en) begin
            r_m3_vld <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_sq    <= $signed(r_m2_s[31:0]) * $signed(r_m2_s[31:0]);
            r_m3_s     <= r_m2_s;
            r_m3_xc    <= r_m2_xc;
            r_m3_se    <= r_m2_se;
            r_m3_clamp <= r_m2_clamp;
        end
    end

    // M4: radicand
    logic               r_m4_vld;
    logic [63:0]        r_m4_n;
    logic [ISIDE_W-1:0] r_m4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m4_vld <= 1'b0;
        end else if (en) begin
            r_m4_vld <= r_m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m4_n    <= (64'(1) << 60) - $unsigned(r_m3_sq);
            r_m4_side <= {r_m3_s, r_m3_xc, r_m3_se, r_m3_clamp};
        end
    end

    // square root
    logic               sq_vld;
    logic [31:0]        root;
    logic [ISIDE_W-1:0] sq_side;

    aez_isqrt #(.SIDE_W(ISIDE_W)) u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_m4_vld), .i_n(r_m4_n), .i_side(r_m4_side),
        .o_valid(sq_vld), .o_root(root), .o_side(sq_side)
    );

    aez_pkg::t_ang    q_s, q_xc, q_se;
    aez_pkg::t_xclamp q_clamp;
    assign {q_s, q_xc, q_se, q_clamp} = sq_side;

    // atan2 chains
    logic             vy_vld, vx_vld_unused, vy_side_unused;
    aez_pkg::t_ang    ang_y, ang_x;
    aez_pkg::t_xclamp v_clamp;

    aez_cordic_vec #(.SIDE_W(1)) u_vec_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(sq_vld), .i_x(AW'(root)), .i_y(q_s), .i_side(1'b0),
        .o_valid(vy_vld), .o_ang(ang_y), .o_side(vy_side_unused)
    );

    aez_cordic_vec #(.SIDE_W(2)) u_vec_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(sq_vld), .i_x(q_se), .i_y(q_xc), .i_side(q_clamp),
        .o_valid(vx_vld_unused), .o_ang(ang_x), .o_side(v_clamp)
    );

    // output stage
    function automatic logic [aez_pkg::AXIS_W-1:0] to_axis(input aez_pkg::t_ang z);
        logic signed [35:0] v;
        logic [35:0]        r;
        v = 36'(aez_pkg::DEG90_Q) - 36'(z);
        if (v < 0) begin
            v = '0;
        end
        if (v > 36'(aez_pkg::DEG180_Q)) begin
            v = 36'(aez_pkg::DEG180_Q);
        end
        r = $unsigned(v + HALF) >> SH;
        return r[aez_pkg::AXIS_W-1:0];
    endfunction

    logic [aez_pkg::AXIS_W-1:0] ax_x;
    always_comb begin
        if (v_clamp.force_90) begin
            ax_x = X90[aez_pkg::AXIS_W-1:0];
        end else if (v_clamp.force_0) begin
            ax_x = '0;
        end else begin
            ax_x = to_axis(ang_x);
        end
    end

    logic                       r_out_vld;
    logic [aez_pkg::AXIS_W-1:0] r_out_x, r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= vy_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x <= ax_x;
            r_out_y <= to_axis(ang_y);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'b0, r_out_y, r_out_x};
endmodule
`default_nettype wire

/* src/aez_checker.sv */
// Port-level assertions for the az/el to X/Y mount converter, bound to its top level.
// Depends on aez_pkg and az_el_to_xy_mount_angles_unit.
`default_nettype none
module aez_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_s_tvalid,
    input wire                             o_s_tready,
    input wire [aez_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input wire                             o_m_tvalid,
    input wire                             i_m_tready,
    input wire [aez_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input wire                             psel,
    input wire                             penable,
    input wire                             pwrite,
    input wire [aez_pkg::PADDR_W-1:0]      paddr,
    input wire [aez_pkg::PDATA_W-1:0]      pwdata,
    input wire [aez_pkg::PDATA_W-1:0]      prdata,
    input wire                             pready
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed during stall");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not track output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[aez_pkg::OUT_TDATA_W-1:36] == '0 && pready)
        else $error("output padding not zero or pready low");
endmodule

bind az_el_to_xy_mount_angles_unit aez_checker u_aez_checker (.*);
`default_nettype wire
